@@ hdl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
// Used by the channel interfaces, the table cell and the top level.
// No dependencies.
package skt_pkg;

    // Field widths fixed by the beat format.
    localparam int CMD_W         = 2;
    localparam int KEY_W         = 32;
    localparam int PAYLOAD_W     = 64;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Default table depth.
    localparam int DEFAULT_CAPACITY = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // One table entry as held in a cell.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload_low;
        logic [PAYLOAD_W-1:0]    payload_high;
    } t_entry;

    // Operation that every cell performs in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    // Control broadcast from the top level to the whole row of cells.
    typedef struct packed {
        t_cell_op op;
        t_entry   entry;
    } t_cell_ctl;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     entry_valid;
        logic signed [KEY_W-1:0]  out_key;
        logic [PAYLOAD_W-1:0]     out_payload_low;
        logic [PAYLOAD_W-1:0]     out_payload_high;
        logic                     last;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_result;

    // Top level sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

@@ hdl/skt_if.sv @@
// Request and response channel interfaces of the sorted key table.
// Depends on skt_pkg for the field widths.
interface skt_req_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload_low;
    logic [PAYLOAD_W-1:0]    payload_high;

    modport source (output valid, cmd, key, payload_low, payload_high, input ready);
    modport sink (input valid, cmd, key, payload_low, payload_high, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     entry_valid;
    logic signed [KEY_W-1:0]  out_key;
    logic [PAYLOAD_W-1:0]     out_payload_low;
    logic [PAYLOAD_W-1:0]     out_payload_high;
    logic                     last;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    modport source (output valid, status, entry_valid, out_key, out_payload_low,
                    out_payload_high, last, entry_count, input ready);
    modport sink (input valid, status, entry_valid, out_key, out_payload_low,
                  out_payload_high, last, entry_count, output ready);
endinterface

@@ hdl/skt_cell.sv @@
// One cell of the sorted table: holds one entry and trades it with its neighbors.
// Depends on skt_pkg.
module skt_cell import skt_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int IDX      = 0,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_head,
    input  t_entry        i_left,
    input  logic          i_left_gt,
    input  t_entry        i_right,
    input  logic          i_found,
    output logic          o_gt,
    output logic          o_found,
    output t_entry        o_entry
);

    localparam logic [CW-1:0] IDX_C    = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1_C = CW'(IDX + 1);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_occupied;
    logic   w_match;

    // Position of this cell relative to the fill level, and key compares.
    assign w_occupied = IDX_C < i_count;
    assign o_gt       = w_occupied && (i_ctl.entry.key < r_entry.key);
    assign w_match    = w_occupied && (i_ctl.entry.key == r_entry.key);
    assign o_found    = i_found || w_match;
    assign o_entry    = r_entry;

    // Next entry: shift right on insert, shift left past a removed entry,
    // or rotate left with the head wrapping to the tail during a dump.
    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (i_left_gt) begin
                    n_entry = i_left;
                end else if (o_gt || (i_count == IDX_C)) begin
                    n_entry = i_ctl.entry;
                end
            end
            CELL_REMOVE: begin
                if (o_found) begin
                    n_entry = i_right;
                end
            end
            CELL_ROTATE: begin
                if (i_count == IDX_P1_C) begin
                    n_entry = i_head;
                end else begin
                    n_entry = i_right;
                end
            end
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ hdl/sorted_key_table.sv @@
// Sorted key table top level: a row of cells, a command sequencer and an output register.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and skt_cell.
//
// The table holds up to CAPACITY entries in ascending signed key order, one
// entry per cell. Insert and remove update the row as the request is taken:
// every cell compares the key at once and shifts toward or away from its
// neighbor, and a new request is taken as soon as the result register is free.
// A dump rotates the row one cell per beat and returns one entry per cycle
// while the result register is free; no request is taken until the last
// entry has left. Every request gives one response beat, or one beat per
// entry for a dump of a non-empty table, with last set on the final beat.
module sorted_key_table import skt_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);

    localparam int            CW    = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    logic          r_out_valid;
    logic          n_out_valid;
    t_result       r_out;
    t_result       n_out;
    logic          w_load_out;
    logic          w_out_free;
    logic          w_accept;
    t_cell_ctl     w_ctl;

    t_entry w_entry [CAPACITY];
    logic   w_gt    [CAPACITY];
    logic   w_found [CAPACITY];

    // Row of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_gt;
        logic   w_found_in;

        if (g == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_gt  = 1'b0;
            assign w_found_in = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_left_gt  = w_gt[g-1];
            assign w_found_in = w_found[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        skt_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g),
            .CW       (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_head    (w_entry[0]),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .i_found   (w_found_in),
            .o_gt      (w_gt[g]),
            .o_found   (w_found[g]),
            .o_entry   (w_entry[g])
        );
    end

    // Handshake.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    // Sequencer: decode the command, drive the row and form the result beat.
    always_comb begin
        n_state                  = r_state;
        n_count                  = r_count;
        n_left                   = r_left;
        w_load_out               = 1'b0;
        w_ctl.op                 = CELL_HOLD;
        w_ctl.entry.key          = i_req.key;
        w_ctl.entry.payload_low  = i_req.payload_low;
        w_ctl.entry.payload_high = i_req.payload_high;
        n_out                    = '0;
        n_out.status             = STATUS_OK;
        n_out.last               = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    priority if (i_req.cmd == CMD_INSERT) begin
                        if (r_count == CAP_C) begin
                            n_out.status = STATUS_FULL;
                        end else begin
                            w_ctl.op = CELL_INSERT;
                            n_count  = r_count + ONE_C;
                        end
                    end else if (i_req.cmd == CMD_REMOVE) begin
                        w_ctl.op = CELL_REMOVE;
                        if (w_found[CAPACITY-1]) begin
                            n_count = r_count - ONE_C;
                        end else begin
                            n_out.status = STATUS_NOT_FOUND;
                        end
                    end else if (i_req.cmd == CMD_DUMP) begin
                        if (r_count != '0) begin
                            w_ctl.op               = CELL_ROTATE;
                            n_out.entry_valid      = 1'b1;
                            n_out.out_key          = w_entry[0].key;
                            n_out.out_payload_low  = w_entry[0].payload_low;
                            n_out.out_payload_high = w_entry[0].payload_high;
                            n_out.last             = (r_count == ONE_C);
                            if (r_count != ONE_C) begin
                                n_left  = r_count - ONE_C;
                                n_state = ST_DUMP;
                            end
                        end
                    end else begin
                        n_out.status = STATUS_OK;
                    end
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    w_load_out             = 1'b1;
                    w_ctl.op               = CELL_ROTATE;
                    n_out.entry_valid      = 1'b1;
                    n_out.out_key          = w_entry[0].key;
                    n_out.out_payload_low  = w_entry[0].payload_low;
                    n_out.out_payload_high = w_entry[0].payload_high;
                    n_out.last             = (r_left == ONE_C);
                    n_left                 = r_left - ONE_C;
                    if (r_left == ONE_C) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out.entry_count = ENTRY_COUNT_W'(n_count);
        n_out_valid       = w_load_out || (r_out_valid && !o_rsp.ready);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    // Response channel.
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out.status;
    assign o_rsp.entry_valid      = r_out.entry_valid;
    assign o_rsp.out_key          = r_out.out_key;
    assign o_rsp.out_payload_low  = r_out.out_payload_low;
    assign o_rsp.out_payload_high = r_out.out_payload_high;
    assign o_rsp.last             = r_out.last;
    assign o_rsp.entry_count      = r_out.entry_count;

`ifndef SYNTHESIS
    // The fill level never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count exceeds capacity");

    // While dumping, beats remain and there are fewer left than entries held.
    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> ((r_left != '0) && (r_left < r_count)))
        else $error("dump beat counter out of range");

    // No request is taken in the middle of a dump.
    a_dump_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> !i_req.ready)
        else $error("request taken during dump");

    // An insert into a table with room grows it by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.cmd == CMD_INSERT) && (r_count != CAP_C))
        |=> (r_count == $past(r_count) + ONE_C))
        else $error("insert did not grow the table");

    // The final dump beat returns the sequencer to idle with last set.
    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DUMP) && w_out_free && (r_left == ONE_C))
        |=> ((r_state == ST_IDLE) && r_out_valid && r_out.last))
        else $error("dump did not end cleanly");
`endif

endmodule
